/* rtl/tsalu_pkg.sv */
// Shared constants, types and type-tag helpers of the typed stack integer ALU.
// Depends on nothing; imported by typed_stack_integer_alu.
package tsalu_pkg;

   localparam int DefStackDepth = 256;

   localparam logic [4:0] OP_PUSH = 5'd0;
   localparam logic [4:0] OP_POP  = 5'd1;
   localparam logic [4:0] OP_DUP  = 5'd2;
   localparam logic [4:0] OP_SWAP = 5'd3;
   localparam logic [4:0] OP_ADD  = 5'd4;
   localparam logic [4:0] OP_SUB  = 5'd5;
   localparam logic [4:0] OP_MUL  = 5'd6;
   localparam logic [4:0] OP_DIV  = 5'd7;
   localparam logic [4:0] OP_MOD  = 5'd8;
   localparam logic [4:0] OP_AND  = 5'd9;
   localparam logic [4:0] OP_OR   = 5'd10;
   localparam logic [4:0] OP_EQ   = 5'd11;
   localparam logic [4:0] OP_NE   = 5'd12;
   localparam logic [4:0] OP_GT   = 5'd13;
   localparam logic [4:0] OP_GE   = 5'd14;
   localparam logic [4:0] OP_LT   = 5'd15;
   localparam logic [4:0] OP_LE   = 5'd16;
   localparam logic [4:0] OP_CAST = 5'd17;

   localparam logic [3:0] TY_BOOL = 4'd0;
   localparam logic [3:0] TY_MAX  = 4'd8;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER  = 3'd2;
   localparam logic [2:0] ST_DIV0  = 3'd3;
   localparam logic [2:0] ST_TYPE  = 3'd4;

   typedef struct packed {
      logic [3:0]  ty;
      logic [63:0] val;
   } entry_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RDB  = 8'b0000_0010,
      S_RDA  = 8'b0000_0100,
      S_EXEC = 8'b0000_1000,
      S_ITER = 8'b0001_0000,
      S_FIN  = 8'b0010_0000,
      S_SWP2 = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   function automatic logic [63:0] ty_mask(input logic [3:0] t);
      logic [63:0] m;
      unique case (t)
         4'd0:       m = 64'd1;
         4'd2, 4'd6: m = 64'h0000_0000_FFFF_FFFF;
         4'd3, 4'd7: m = 64'h0000_0000_0000_FFFF;
         4'd4, 4'd8: m = 64'h0000_0000_0000_00FF;
         default:    m = '1;
      endcase
      return m;
   endfunction

   function automatic logic ty_signed(input logic [3:0] t);
      return (t >= 4'd1) && (t <= 4'd4);
   endfunction

   // Sign- or zero-extend the low bits of a value per its type.
   function automatic logic [63:0] ty_ext(input logic [63:0] v, input logic [3:0] t);
      logic [63:0] m;
      logic [63:0] x;
      m = ty_mask(t);
      x = v & m;
      if (ty_signed(t) && (m != '1) && ((x & ((m >> 1) + 64'd1)) != 64'd0)) begin
         x = x | ~m;
      end
      return x;
   endfunction

endpackage

/* rtl/typed_stack_integer_alu.sv */
// Top level of the typed stack integer ALU: sequencer, stack memory and the
// shared shift-add/subtract unit. Depends on tsalu_pkg.
//
// One instruction word is taken at a time. The stack lives in a single-port
// write, single-port read memory with registered read data, so each word
// reads the top entry, then the one below it, executes, and writes back.
// Plain instructions pass through accept, two memory reads, execute and
// result before the next acceptance; swap adds a second write step because
// it writes two entries through the one write port; mul, div and mod add
// iteration steps, as the shared unit retires one bit per cycle until all 64
// bits are done, then a finishing step fixes signs and writes back. The result
// sits in an output register, so a new word may be accepted while it waits.
// The stack needs no clearing pass: only entries below the stack pointer
// are ever used.
module typed_stack_integer_alu #(
   parameter int STACK_DEPTH = tsalu_pkg::DefStackDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_opcode,
   input  logic [3:0]  req_value_type,
   input  logic [63:0] req_push_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic [3:0]  rsp_result_type,
   output logic [8:0]  rsp_stack_count,
   output logic [2:0]  rsp_status
);
   import tsalu_pkg::*;

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] SpFull = SPW'(STACK_DEPTH);
   localparam logic [SPW-1:0] SpOne  = SPW'(1);
   localparam logic [SPW-1:0] SpTwo  = SPW'(2);

   entry_type stack_mem [STACK_DEPTH];
   entry_type mem_q_ff;

   state_type        state_ff, state_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic [4:0]       op_ff, op_in;
   logic [3:0]       vt_ff, vt_in;
   logic [63:0]      pv_ff, pv_in;
   entry_type        b_ff, b_in;
   entry_type        res_ff, res_in;
   logic [2:0]       st_ff, st_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      opa_ff, opa_in;
   logic [63:0]      opb_ff, opb_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [3:0]       ta_ff, ta_in;
   logic             na_ff, na_in;
   logic             nb_ff, nb_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rsp_ent_ff, rsp_ent_in;
   logic [8:0]       rsp_cnt_ff, rsp_cnt_in;
   logic [2:0]       rsp_st_ff, rsp_st_in;

   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;

   logic [SPW-1:0]   sp_m1, sp_m2;
   logic [AW-1:0]    addr_top, addr_next, addr_push;
   logic             out_free;

   assign sp_m1     = sp_ff - SpOne;
   assign sp_m2     = sp_ff - SpTwo;
   assign addr_top  = sp_m1[AW-1:0];
   assign addr_next = sp_m2[AW-1:0];
   assign addr_push = sp_ff[AW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= stack_mem[rd_addr];
      end
   end

   always_comb begin
      logic [3:0]  ta;
      logic [63:0] va, vb, m, ea, eb, ka, kb, sum, ec, cast_r, bin_r, fin_r;
      logic        sgn, k_eq, k_lt, is_sub;
      logic [64:0] rem_sh, diff;

      ta     = mem_q_ff.ty;
      va     = mem_q_ff.val;
      vb     = b_ff.val;
      m      = ty_mask(ta);
      sgn    = ty_signed(ta);
      ea     = ty_ext(va, ta);
      eb     = ty_ext(vb, ta);
      ka     = ea ^ {sgn, 63'd0};
      kb     = eb ^ {sgn, 63'd0};
      k_eq   = (ka == kb);
      k_lt   = (ka < kb);
      is_sub = (op_ff == OP_SUB);
      sum    = va + (is_sub ? ~vb : vb) + {63'd0, is_sub};

      ec = ty_ext(b_ff.val, b_ff.ty);
      if (vt_ff == TY_BOOL) begin
         cast_r = ty_signed(b_ff.ty) ? {63'd0, (ec != 64'd0) && !ec[63]}
                                     : {63'd0, ec != 64'd0};
      end else begin
         cast_r = ec & ty_mask(vt_ff);
      end

      unique case (op_ff)
         OP_ADD, OP_SUB: bin_r = sum & m;
         OP_AND:  bin_r = {63'd0, (va != 64'd0) && (vb != 64'd0)};
         OP_OR:   bin_r = {63'd0, (va != 64'd0) || (vb != 64'd0)};
         OP_EQ:   bin_r = {63'd0, k_eq};
         OP_NE:   bin_r = {63'd0, !k_eq};
         OP_GT:   bin_r = {63'd0, !k_lt && !k_eq};
         OP_GE:   bin_r = {63'd0, !k_lt};
         OP_LT:   bin_r = {63'd0, k_lt};
         OP_LE:   bin_r = {63'd0, k_lt || k_eq};
         default: bin_r = 64'd0;
      endcase

      // Finishing step of the shared unit: fix signs, trim to the type.
      unique case (op_ff)
         OP_DIV:  fin_r = (na_ff ^ nb_ff) ? (64'd0 - opa_ff) : opa_ff;
         OP_MOD:  fin_r = na_ff ? (64'd0 - acc_ff) : acc_ff;
         default: fin_r = acc_ff;
      endcase
      fin_r = fin_r & ty_mask(ta_ff);

      rem_sh = {acc_ff, opa_ff[63]};
      diff   = rem_sh - {1'b0, opb_ff};

      state_in     = state_ff;
      sp_in        = sp_ff;
      op_in        = op_ff;
      vt_in        = vt_ff;
      pv_in        = pv_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      cnt_in       = cnt_ff;
      ta_in        = ta_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ent_in   = rsp_ent_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_top;
      wr_en        = 1'b0;
      wr_addr      = addr_top;
      wr_data      = b_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               vt_in    = req_value_type;
               pv_in    = req_push_value;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            // fetch the top entry
            rd_en    = 1'b1;
            rd_addr  = addr_top;
            state_in = S_RDA;
         end
         S_RDA: begin
            // hold the top, fetch the one beneath it
            b_in     = mem_q_ff;
            rd_en    = 1'b1;
            rd_addr  = addr_next;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // unchanged top is the default answer
            st_in    = ST_OK;
            res_in   = (sp_ff != '0) ? b_ff : '0;
            state_in = S_OUT;
            if ((op_ff == OP_PUSH) || (op_ff == OP_DUP)) begin
               if ((op_ff == OP_DUP) && (sp_ff == '0)) begin
                  st_in = ST_UNDER;
               end else if (sp_ff >= SpFull) begin
                  st_in = ST_OVER;
               end else if ((op_ff == OP_PUSH) && (vt_ff > TY_MAX)) begin
                  st_in = ST_TYPE;
               end else begin
                  if (op_ff == OP_PUSH) begin
                     res_in.ty  = vt_ff;
                     res_in.val = pv_ff & ty_mask(vt_ff);
                  end else begin
                     res_in = b_ff;
                  end
                  wr_en   = 1'b1;
                  wr_addr = addr_push;
                  wr_data = res_in;
                  sp_in   = sp_ff + SpOne;
               end
            end else if (op_ff == OP_POP) begin
               if (sp_ff == '0) begin
                  st_in = ST_UNDER;
               end else begin
                  res_in = b_ff;
                  sp_in  = sp_m1;
               end
            end else if (op_ff == OP_CAST) begin
               if (sp_ff == '0) begin
                  st_in = ST_UNDER;
               end else if (vt_ff > TY_MAX) begin
                  st_in = ST_TYPE;
               end else begin
                  res_in.ty  = vt_ff;
                  res_in.val = cast_r;
                  wr_en      = 1'b1;
                  wr_addr    = addr_top;
                  wr_data    = res_in;
               end
            end else if ((op_ff >= OP_SWAP) && (op_ff <= OP_LE)) begin
               if (sp_ff < SpTwo) begin
                  st_in = ST_UNDER;
               end else if (op_ff == OP_SWAP) begin
                  // write the old top below now, the old second on top next
                  wr_en    = 1'b1;
                  wr_addr  = addr_next;
                  wr_data  = b_ff;
                  res_in   = mem_q_ff;
                  state_in = S_SWP2;
               end else if ((op_ff <= OP_MOD) && (ta == TY_BOOL)) begin
                  st_in = ST_TYPE;
               end else if (((op_ff == OP_DIV) || (op_ff == OP_MOD)) &&
                            ((vb & m) == 64'd0)) begin
                  st_in = ST_DIV0;
               end else if ((op_ff == OP_MUL) || (op_ff == OP_DIV) ||
                            (op_ff == OP_MOD)) begin
                  acc_in   = 64'd0;
                  cnt_in   = 6'd0;
                  ta_in    = ta;
                  na_in    = sgn && ea[63];
                  nb_in    = sgn && eb[63];
                  if (op_ff == OP_MUL) begin
                     opa_in = va;
                     opb_in = vb;
                  end else if (sgn) begin
                     opa_in = ea[63] ? (64'd0 - ea) : ea;
                     opb_in = eb[63] ? (64'd0 - eb) : eb;
                  end else begin
                     opa_in = va & m;
                     opb_in = vb & m;
                  end
                  state_in = S_ITER;
               end else begin
                  res_in.ty  = (op_ff >= OP_AND) ? TY_BOOL : ta;
                  res_in.val = bin_r;
                  wr_en      = 1'b1;
                  wr_addr    = addr_next;
                  wr_data    = res_in;
                  sp_in      = sp_m1;
               end
            end
         end
         S_ITER: begin
            // one multiplier or quotient bit per cycle
            if (op_ff == OP_MUL) begin
               if (opb_ff[0]) begin
                  acc_in = acc_ff + opa_ff;
               end
               opa_in = {opa_ff[62:0], 1'b0};
               opb_in = {1'b0, opb_ff[63:1]};
            end else begin
               if (!diff[64]) begin
                  acc_in = diff[63:0];
               end else begin
                  acc_in = rem_sh[63:0];
               end
               opa_in = {opa_ff[62:0], !diff[64]};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in.ty  = ta_ff;
            res_in.val = fin_r;
            wr_en      = 1'b1;
            wr_addr    = addr_next;
            wr_data    = res_in;
            sp_in      = sp_m1;
            state_in   = S_OUT;
         end
         S_SWP2: begin
            wr_en    = 1'b1;
            wr_addr  = addr_top;
            wr_data  = mem_q_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            // advance once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = res_ff;
               rsp_cnt_in   = 9'(sp_ff);
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      vt_ff      <= vt_in;
      pv_ff      <= pv_in;
      b_ff       <= b_in;
      res_ff     <= res_in;
      st_ff      <= st_in;
      acc_ff     <= acc_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      cnt_ff     <= cnt_in;
      ta_ff      <= ta_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      rsp_ent_ff <= rsp_ent_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ent_ff.val;
   assign rsp_result_type  = rsp_ent_ff.ty;
   assign rsp_stack_count  = rsp_cnt_ff;
   assign rsp_status       = rsp_st_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpFull)
      else $error("stack pointer beyond depth");

   a_sp_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) && (state_ff != S_FIN) |=> $stable(sp_ff))
      else $error("stack pointer moved outside commit");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_RDB))
      else $error("accepted word did not start a read");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

endmodule
